/* hw/rtl/hxw_pkg.sv */
// ----------------------------------------------------------------------------
// hxw_pkg: shared types and constants for the hex record image writer
// Payload structs, parser phases, configuration indexes and the digit decoder.
// ----------------------------------------------------------------------------
package hxw_pkg;

    localparam int ADDR_BITS = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_GAP = 2'd1;

    localparam logic [CFG_DATA_W-1:0] MAX_SIZE_RESET = 33'd1048576;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_F = 8'h46;

    localparam logic [3:0] REC_DATA = 4'd0;
    localparam logic [3:0] REC_EXT_SEG = 4'd2;
    localparam logic [3:0] REC_EXT_LIN = 4'd4;

    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef enum logic [3:0] {
        PH_WAIT    = 4'd0,
        PH_LEN     = 4'd1,
        PH_ADDR    = 4'd2,
        PH_TYPE_HI = 4'd3,
        PH_TYPE_LO = 4'd4,
        PH_DATA    = 4'd5,
        PH_EXT2    = 4'd6,
        PH_EXT4    = 4'd7
    } t_phase;

    typedef struct packed {
        logic [7:0] char_in;
        logic       new_file;
    } t_in;

    typedef struct packed {
        logic        write_valid;
        logic [31:0] write_addr;
        logic [7:0]  write_data;
        logic        out_of_range;
        logic        finished;
        logic [31:0] image_size;
    } t_out;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic       clear;
        logic       byte_done;
        t_addr      addr;
        logic [7:0] data;
        logic       done;
    } t_cmd;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] r;
        r = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            r = 4'(c - CHAR_ZERO);
        end else if (c >= CHAR_A && c <= CHAR_F) begin
            r = 4'(c - CHAR_A + 8'd10);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/hxw_front.sv */
// ----------------------------------------------------------------------------
// hxw_front: record parser
// Takes one character per beat, tracks the record fields, base and write
// pointer, and hands one command per character to the command queue.
// ----------------------------------------------------------------------------
module hxw_front
    import hxw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_fire,
    input  t_in     i_in,
    output t_cmd    o_cmd
);

    t_phase      r_phase, n_phase, c_phase;
    logic [2:0]  r_cnt, n_cnt, c_cnt;
    logic [15:0] r_accum, n_accum, c_accum;
    logic [7:0]  r_rec_len, n_rec_len, c_rec_len;
    logic [15:0] r_rec_addr, n_rec_addr, c_rec_addr;
    logic [7:0]  r_left, n_left, c_left;
    t_addr       r_base, n_base, c_base;
    t_addr       r_wptr, n_wptr, c_wptr;
    logic        r_done, n_done, c_done;
    logic        r_skip;

    logic        clr;
    logic [3:0]  nib;
    logic [15:0] acc_next;
    logic [2:0]  cnt_inc;
    logic [7:0]  left_dec;

    assign clr      = i_in.new_file;
    assign nib      = hex_nibble(i_in.char_in);
    assign c_phase  = clr ? PH_WAIT : r_phase;
    assign c_cnt    = clr ? 3'd0 : r_cnt;
    assign c_accum  = clr ? 16'd0 : r_accum;
    assign c_rec_len  = clr ? 8'd0 : r_rec_len;
    assign c_rec_addr = clr ? 16'd0 : r_rec_addr;
    assign c_left   = clr ? 8'd0 : r_left;
    assign c_base   = clr ? '0 : r_base;
    assign c_wptr   = clr ? '0 : r_wptr;
    assign c_done   = clr ? 1'b0 : r_done;
    assign acc_next = {c_accum[11:0], nib};
    assign cnt_inc  = c_cnt + 3'd1;
    assign left_dec = c_left - 8'd1;

    always_comb begin
        n_phase = c_phase;
        if (!c_done) begin
            unique case (c_phase)
                PH_WAIT: begin
                    if (i_in.char_in == CHAR_COLON) n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (cnt_inc >= 3'd2) n_phase = PH_ADDR;
                end
                PH_ADDR: begin
                    if (cnt_inc >= 3'd4) n_phase = PH_TYPE_HI;
                end
                PH_TYPE_HI: begin
                    n_phase = PH_TYPE_LO;
                end
                PH_TYPE_LO: begin
                    if (nib == REC_DATA) begin
                        n_phase = (c_rec_len == 8'd0) ? PH_WAIT : PH_DATA;
                    end else if (nib == REC_EXT_SEG) begin
                        n_phase = PH_EXT2;
                    end else if (nib == REC_EXT_LIN) begin
                        n_phase = PH_EXT4;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
                PH_DATA: begin
                    if (c_cnt != 3'd0 && left_dec == 8'd0) n_phase = PH_WAIT;
                end
                PH_EXT2, PH_EXT4: begin
                    if (cnt_inc >= 3'd4) n_phase = PH_WAIT;
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
        end
    end

    always_comb begin
        n_cnt      = c_cnt;
        n_accum    = c_accum;
        n_rec_len  = c_rec_len;
        n_rec_addr = c_rec_addr;
        n_left     = c_left;
        n_base     = c_base;
        n_wptr     = c_wptr;
        n_done     = c_done;
        o_cmd           = '0;
        o_cmd.clear     = clr;
        if (!c_done) begin
            unique case (c_phase)
                PH_WAIT: begin
                    if (i_in.char_in == CHAR_COLON) begin
                        n_cnt   = 3'd0;
                        n_accum = 16'd0;
                    end
                end
                PH_LEN: begin
                    n_accum = acc_next;
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= 3'd2) begin
                        n_rec_len = acc_next[7:0];
                        n_cnt     = 3'd0;
                        n_accum   = 16'd0;
                    end
                end
                PH_ADDR: begin
                    n_accum = acc_next;
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= 3'd4) begin
                        n_rec_addr = acc_next;
                        if (r_skip && c_wptr == '0) begin
                            n_base = t_addr'(0) - ADDR_BITS'(acc_next);
                        end
                        n_cnt   = 3'd0;
                        n_accum = 16'd0;
                    end
                end
                PH_TYPE_HI: begin
                end
                PH_TYPE_LO: begin
                    if (nib == REC_DATA) begin
                        n_wptr = ADDR_BITS'(c_rec_addr) + c_base;
                        if (c_rec_len == 8'd0) begin
                            n_done = 1'b1;
                        end else begin
                            n_left = c_rec_len;
                        end
                    end else if (nib != REC_EXT_SEG && nib != REC_EXT_LIN) begin
                        n_done = 1'b1;
                    end
                    n_cnt   = 3'd0;
                    n_accum = 16'd0;
                end
                PH_DATA: begin
                    if (c_cnt == 3'd0) begin
                        n_accum = {12'd0, nib};
                        n_cnt   = 3'd1;
                    end else begin
                        o_cmd.byte_done = 1'b1;
                        o_cmd.data      = acc_next[7:0];
                        o_cmd.addr      = c_wptr;
                        n_wptr  = c_wptr + t_addr'(1);
                        n_cnt   = 3'd0;
                        n_accum = 16'd0;
                        n_left  = left_dec;
                    end
                end
                PH_EXT2, PH_EXT4: begin
                    n_accum = acc_next;
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= 3'd4) begin
                        if (c_phase == PH_EXT2) begin
                            n_base = ADDR_BITS'({acc_next, 4'd0});
                        end else begin
                            n_base = ADDR_BITS'({acc_next, 16'd0});
                        end
                        if (c_rec_len == 8'd0) n_done = 1'b1;
                        n_cnt   = 3'd0;
                        n_accum = 16'd0;
                    end
                end
                default: begin
                    n_cnt   = 3'd0;
                    n_accum = 16'd0;
                end
            endcase
        end
        o_cmd.done = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_cnt      <= 3'd0;
            r_accum    <= 16'd0;
            r_rec_len  <= 8'd0;
            r_rec_addr <= 16'd0;
            r_left     <= 8'd0;
            r_base     <= '0;
            r_wptr     <= '0;
            r_done     <= 1'b0;
            r_skip     <= 1'b0;
        end else begin
            if (i_fire) begin
                r_phase    <= n_phase;
                r_cnt      <= n_cnt;
                r_accum    <= n_accum;
                r_rec_len  <= n_rec_len;
                r_rec_addr <= n_rec_addr;
                r_left     <= n_left;
                r_base     <= n_base;
                r_wptr     <= n_wptr;
                r_done     <= n_done;
            end
            if (i_cfg.valid && i_cfg.index == CFG_SKIP_GAP) begin
                r_skip <= i_cfg.data[0];
            end
        end
    end

endmodule

/* hw/rtl/hxw_fifo.sv */
// ----------------------------------------------------------------------------
// hxw_fifo: two-entry command queue
// Decouples the parser from the range check and output stage.
// ----------------------------------------------------------------------------
module hxw_fifo
    import hxw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop) r_rd_ptr <= ~r_rd_ptr;
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* hw/rtl/hxw_back.sv */
// ----------------------------------------------------------------------------
// hxw_back: range check, image size tracking and output register
// Checks each completed byte against the configured maximum size and registers the result.
// ----------------------------------------------------------------------------
module hxw_back
    import hxw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_empty,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out
);

    logic [CFG_DATA_W-1:0] r_max;
    logic [31:0]           r_size;
    logic [31:0]           n_size;
    logic                  r_out_valid;
    t_out                  r_out;
    t_out                  n_out;
    logic [31:0]           size_cur;
    logic [31:0]           addr32;
    logic [31:0]           end_pos;
    logic                  in_range;

    assign o_pop       = !i_empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign size_cur = i_cmd.clear ? 32'd0 : r_size;
    assign addr32   = 32'(i_cmd.addr);
    assign end_pos  = (addr32 == 32'hFFFF_FFFF) ? addr32 : addr32 + 32'd1;
    assign in_range = {1'b0, addr32} < r_max;

    always_comb begin
        n_size = size_cur;
        n_out  = '0;
        n_out.write_addr = addr32;
        n_out.write_data = i_cmd.data;
        if (i_cmd.byte_done) begin
            if (in_range) begin
                n_out.write_valid = 1'b1;
                if (end_pos > size_cur) n_size = end_pos;
            end else begin
                n_out.out_of_range = 1'b1;
            end
        end
        n_out.finished   = i_cmd.done;
        n_out.image_size = n_size;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= MAX_SIZE_RESET;
            r_size      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_size      <= n_size;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.index == CFG_MAX_SIZE) begin
                r_max <= i_cfg.data;
            end
        end
    end

endmodule

/* hw/rtl/hex_record_to_image_writer.sv */
// ----------------------------------------------------------------------------
// hex_record_to_image_writer: Intel HEX text to byte image writes
// Parses records one character per beat and emits one result per character.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      i_in_valid / o_in_ready    i_in  (t_in)
//   out      output     o_out_valid / i_out_ready  o_out (t_out)
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One character is accepted per cycle while the queue is not full. The parser
// is combinational, so its command enters the queue at the accepting edge and
// moves into the output register once that register is empty or being taken.
// A two-entry queue between the parser and the output stage lets input keep
// flowing while the output is stalled, until the queue fills. Synchronous
// active-low reset clears the parser, the image size and the output valid.
// ----------------------------------------------------------------------------
module hex_record_to_image_writer
    import hxw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg_wr cfg;
    t_cmd    front_cmd;
    t_cmd    queue_cmd;
    logic    fire;
    logic    full;
    logic    empty;
    logic    pop;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    assign o_in_ready = !full;
    assign fire       = i_in_valid && !full;

    hxw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_in    (i_in),
        .o_cmd   (front_cmd)
    );

    hxw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    hxw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_empty     (empty),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
